// ----- rtl/wrhp_pkg.sv -----
// Package for the RIFF/WAVE header parser: record codes, phases, tags, widths.
// No dependencies.
package wrhp_pkg;

  localparam int unsigned FractionBitsDefault = 16;
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_TEXT  = 2'd1;
  localparam logic [1:0] KIND_SUM   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_RIFF = 2'd1;
  localparam logic [1:0] ST_NO_WAVE = 2'd2;

  localparam logic [2:0] TAG_TRACK = 3'd5;
  localparam logic [2:0] TAG_NONE  = 3'd7;

  localparam logic [3:0] PH_RIFF  = 4'd0;
  localparam logic [3:0] PH_RSIZE = 4'd1;
  localparam logic [3:0] PH_WAVE  = 4'd2;
  localparam logic [3:0] PH_CID   = 4'd3;
  localparam logic [3:0] PH_CSIZE = 4'd4;
  localparam logic [3:0] PH_FMT   = 4'd5;
  localparam logic [3:0] PH_SKIP  = 4'd6;
  localparam logic [3:0] PH_LTYPE = 4'd7;
  localparam logic [3:0] PH_SID   = 4'd8;
  localparam logic [3:0] PH_SSIZE = 4'd9;
  localparam logic [3:0] PH_SDATA = 4'd10;
  localparam logic [3:0] PH_PAD   = 4'd11;
  localparam logic [3:0] PH_HALT  = 4'd12;

  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT  = 32'h2074_6d66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;
  localparam logic [31:0] ID_LIST = 32'h5453_494c;
  localparam logic [31:0] ID_INAM = 32'h4d41_4e49;
  localparam logic [31:0] ID_IART = 32'h5452_4149;
  localparam logic [31:0] ID_IPRD = 32'h4452_5049;
  localparam logic [31:0] ID_IGNR = 32'h524e_4749;
  localparam logic [31:0] ID_ICRD = 32'h4452_4349;
  localparam logic [31:0] ID_ITRK = 32'h4b52_5449;
  localparam logic [31:0] FMT_BODY = 32'd16;

  // One entry of the queue between front and back.
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  tag;
    logic [7:0]  text;
    logic [1:0]  status;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [31:0] data_size;
    logic [31:0] track;
  } wrhp_rec_t;

endpackage

// ----- rtl/wrhp_if.sv -----
// Valid/ready channel interfaces for the input bytes and the result records.
// No dependencies.
interface wrhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;
  modport source (output valid, data_byte, end_of_file, input ready);
  modport sink (input valid, data_byte, end_of_file, output ready);
endinterface

interface wrhp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [2:0]  text_tag;
  logic [7:0]  text_byte;
  logic [1:0]  parse_status;
  logic [31:0] sample_rate_out;
  logic [31:0] byte_rate_out;
  logic [31:0] data_size_out;
  logic [31:0] track_out;
  logic [31:0] duration_seconds;
  logic [15:0] duration_fraction;
  logic        last_flag;
  modport source (output valid, record_kind, text_tag, text_byte, parse_status,
                  sample_rate_out, byte_rate_out, data_size_out, track_out,
                  duration_seconds, duration_fraction, last_flag, input ready);
  modport sink (input valid, record_kind, text_tag, text_byte, parse_status,
                sample_rate_out, byte_rate_out, data_size_out, track_out,
                duration_seconds, duration_fraction, last_flag, output ready);
endinterface

// ----- rtl/wav_riff_header_parser.sv -----
// Top level of the RIFF/WAVE header parser.
// Depends on wrhp_pkg, wrhp_if, wrhp_front, wrhp_queue, wrhp_back.
//
// Takes a WAV file one byte per beat and emits clear and text records for LIST/INFO
// strings and one summary record per end beat. The byte walker takes one beat
// per cycle while the record queue has room. A text record passes through the
// queue and the output register and can wait there behind a busy divider or
// a stalled output. A summary with nonzero rates runs a bit-serial divider;
// meanwhile later records wait and bytes keep flowing until the queue fills.
module wav_riff_header_parser #(
  parameter int unsigned FRACTION_BITS = wrhp_pkg::FractionBitsDefault,
  parameter int unsigned QUEUE_DEPTH   = wrhp_pkg::QueueDepthDefault
) (
  input logic   clk,
  input logic   rst_n,
  wrhp_in_if.sink    in_ch,
  wrhp_out_if.source out_ch
);
  import wrhp_pkg::*;

  logic      push, q_full, q_empty, q_pop;
  wrhp_rec_t push_rec, q_head;

  wrhp_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_data_byte(in_ch.data_byte), .in_end_of_file(in_ch.end_of_file),
    .push, .push_rec, .q_full
  );

  wrhp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push, .push_rec, .full(q_full),
    .pop(q_pop), .empty(q_empty), .head(q_head)
  );

  wrhp_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk, .rst_n, .q_empty, .q_head, .q_pop,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_record_kind(out_ch.record_kind), .out_text_tag(out_ch.text_tag),
    .out_text_byte(out_ch.text_byte), .out_parse_status(out_ch.parse_status),
    .out_sample_rate_out(out_ch.sample_rate_out),
    .out_byte_rate_out(out_ch.byte_rate_out),
    .out_data_size_out(out_ch.data_size_out), .out_track_out(out_ch.track_out),
    .out_duration_seconds(out_ch.duration_seconds),
    .out_duration_fraction(out_ch.duration_fraction),
    .out_last_flag(out_ch.last_flag)
  );
endmodule

// ----- rtl/wrhp_front.sv -----
// Byte-level chunk walker: classifies each byte, latches header fields and
// pushes text records and summary requests. Depends on wrhp_pkg.
module wrhp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_end_of_file,
  output logic                push,
  output wrhp_pkg::wrhp_rec_t push_rec,
  input  logic                q_full
);
  import wrhp_pkg::*;

  logic [3:0]  phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [31:0] word_r, word_nxt;
  logic [31:0] ctag_r, ctag_nxt;
  logic [31:0] crem_r, crem_nxt;
  logic [31:0] lrem_r, lrem_nxt;
  logic [2:0]  cur_r, cur_nxt;
  logic        nul_r, nul_nxt;
  logic        pad_r, pad_nxt;
  logic        dig_r, dig_nxt;
  logic [31:0] srate_r, srate_nxt;
  logic [31:0] brate_r, brate_nxt;
  logic [31:0] dsize_r, dsize_nxt;
  logic [31:0] track_r, track_nxt;
  logic [1:0]  err_r, err_nxt;

  logic        take;
  logic [31:0] shifted;
  logic        word_done;
  logic [3:0]  idx_inc;
  logic [31:0] crem_dec;
  logic [3:0]  digit;
  logic [35:0] track_x10;
  logic [36:0] track_sum;
  logic [1:0]  status;
  logic [3:0]  boundary;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign shifted  = {in_data_byte, word_r[31:8]};
  assign idx_inc  = idx_r + 4'd1;
  assign word_done = (idx_inc >= 4'd4);
  assign crem_dec = (crem_r != 32'd0) ? crem_r - 32'd1 : 32'd0;
  assign digit    = in_data_byte[3:0];
  assign track_x10 = {1'b0, track_r, 3'b000} + {3'b000, track_r, 1'b0};
  assign track_sum = {1'b0, track_x10} + 37'(digit);

  always_comb begin
    status = err_r;
    if (err_r == ST_OK) begin
      if (phase_r == PH_RIFF) status = ST_NO_RIFF;
      else if (phase_r == PH_RSIZE || phase_r == PH_WAVE) status = ST_NO_WAVE;
    end
  end

  always_comb begin
    phase_nxt = phase_r; idx_nxt = idx_r; word_nxt = word_r; ctag_nxt = ctag_r;
    crem_nxt = crem_r; lrem_nxt = lrem_r; cur_nxt = cur_r; nul_nxt = nul_r;
    pad_nxt = pad_r; dig_nxt = dig_r; srate_nxt = srate_r; brate_nxt = brate_r;
    dsize_nxt = dsize_r; track_nxt = track_r; err_nxt = err_r;
    push = 1'b0;
    push_rec = '0;
    boundary = (lrem_nxt == 32'd0) ? PH_CID : PH_SID;
    if (take && in_end_of_file) begin
      push = 1'b1;
      push_rec.kind = KIND_SUM;
      push_rec.status = status;
      if (status == ST_OK) begin
        push_rec.sample_rate = srate_r;
        push_rec.byte_rate = brate_r;
        push_rec.data_size = dsize_r;
        push_rec.track = track_r;
      end
      phase_nxt = PH_RIFF; idx_nxt = '0; word_nxt = '0; ctag_nxt = '0;
      crem_nxt = '0; lrem_nxt = '0; cur_nxt = TAG_NONE; nul_nxt = 1'b0;
      pad_nxt = 1'b0; dig_nxt = 1'b1; srate_nxt = '0; brate_nxt = '0;
      dsize_nxt = '0; track_nxt = '0; err_nxt = ST_OK;
    end else if (take) begin
      if (phase_r >= PH_LTYPE && phase_r <= PH_PAD && lrem_r != 32'd0)
        lrem_nxt = lrem_r - 32'd1;
      boundary = (lrem_nxt == 32'd0) ? PH_CID : PH_SID;
      if (phase_r != PH_FMT && phase_r != PH_SKIP && phase_r != PH_SDATA &&
          phase_r != PH_PAD && phase_r != PH_HALT) begin
        word_nxt = shifted;
        idx_nxt = word_done ? 4'd0 : idx_inc;
      end
      unique case (phase_r)
        PH_RIFF: if (word_done) begin
          if (shifted == ID_RIFF) phase_nxt = PH_RSIZE;
          else begin err_nxt = ST_NO_RIFF; phase_nxt = PH_HALT; end
        end
        PH_RSIZE: if (word_done) phase_nxt = PH_WAVE;
        PH_WAVE: if (word_done) begin
          if (shifted == ID_WAVE) phase_nxt = PH_CID;
          else begin err_nxt = ST_NO_WAVE; phase_nxt = PH_HALT; end
        end
        PH_CID: if (word_done) begin
          ctag_nxt = shifted; phase_nxt = PH_CSIZE;
        end
        PH_CSIZE: if (word_done) begin
          if (ctag_r == ID_FMT) begin
            crem_nxt = (shifted > FMT_BODY) ? shifted - FMT_BODY : 32'd0;
            phase_nxt = PH_FMT;
          end else if (ctag_r == ID_LIST) begin
            lrem_nxt = shifted; phase_nxt = PH_LTYPE;
          end else begin
            if (ctag_r == ID_DATA) dsize_nxt = shifted;
            crem_nxt = shifted;
            phase_nxt = (shifted == 32'd0) ? PH_CID : PH_SKIP;
          end
        end
        PH_FMT: begin
          word_nxt = shifted;
          if (idx_r == 4'd7) srate_nxt = shifted;
          else if (idx_r == 4'd11) brate_nxt = shifted;
          if (idx_r == 4'd15) begin
            idx_nxt = 4'd0;
            phase_nxt = (crem_r == 32'd0) ? PH_CID : PH_SKIP;
          end else idx_nxt = idx_inc;
        end
        PH_SKIP: begin
          crem_nxt = crem_dec;
          if (crem_dec == 32'd0) phase_nxt = PH_CID;
        end
        PH_LTYPE: if (word_done) phase_nxt = boundary;
        PH_SID: if (word_done) begin
          ctag_nxt = shifted; phase_nxt = PH_SSIZE;
        end
        PH_SSIZE: if (word_done) begin
          priority if (ctag_r == ID_INAM) cur_nxt = 3'd0;
          else if (ctag_r == ID_IART) cur_nxt = 3'd1;
          else if (ctag_r == ID_IPRD) cur_nxt = 3'd2;
          else if (ctag_r == ID_IGNR) cur_nxt = 3'd3;
          else if (ctag_r == ID_ICRD) cur_nxt = 3'd4;
          else if (ctag_r == ID_ITRK) cur_nxt = TAG_TRACK;
          else cur_nxt = TAG_NONE;
          crem_nxt = shifted;
          pad_nxt = shifted[0];
          nul_nxt = 1'b0;
          if (cur_nxt == TAG_TRACK) begin
            track_nxt = '0; dig_nxt = 1'b1;
          end else if (cur_nxt < TAG_TRACK) begin
            push = 1'b1; push_rec.kind = KIND_CLEAR; push_rec.tag = cur_nxt;
          end
          if (shifted == 32'd0) phase_nxt = shifted[0] ? PH_PAD : boundary;
          else phase_nxt = PH_SDATA;
        end
        PH_SDATA: begin
          if (cur_r < TAG_TRACK) begin
            if (!nul_r) begin
              if (in_data_byte == 8'd0) nul_nxt = 1'b1;
              else begin
                push = 1'b1; push_rec.kind = KIND_TEXT;
                push_rec.tag = cur_r; push_rec.text = in_data_byte;
              end
            end
          end else if (cur_r == TAG_TRACK && dig_r) begin
            if (in_data_byte >= 8'h30 && in_data_byte <= 8'h39) begin
              // saturate when the decimal shift-in overflows 32 bits
              track_nxt = (track_sum[36:32] != 5'd0) ? 32'hFFFF_FFFF : track_sum[31:0];
            end else dig_nxt = 1'b0;
          end
          crem_nxt = crem_dec;
          if (crem_dec == 32'd0) phase_nxt = pad_r ? PH_PAD : boundary;
        end
        PH_PAD: begin
          pad_nxt = 1'b0; phase_nxt = boundary;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RIFF; idx_r <= '0; word_r <= '0; ctag_r <= '0; crem_r <= '0;
      lrem_r <= '0; cur_r <= TAG_NONE; nul_r <= 1'b0; pad_r <= 1'b0; dig_r <= 1'b1;
      srate_r <= '0; brate_r <= '0; dsize_r <= '0; track_r <= '0; err_r <= ST_OK;
    end else begin
      phase_r <= phase_nxt; idx_r <= idx_nxt; word_r <= word_nxt; ctag_r <= ctag_nxt;
      crem_r <= crem_nxt; lrem_r <= lrem_nxt; cur_r <= cur_nxt; nul_r <= nul_nxt;
      pad_r <= pad_nxt; dig_r <= dig_nxt; srate_r <= srate_nxt; brate_r <= brate_nxt;
      dsize_r <= dsize_nxt; track_r <= track_nxt; err_r <= err_nxt;
    end
  end

  a_halt_err: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HALT |-> err_r != ST_OK) else $error("halt without error");
  a_err_halt: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != ST_OK |-> phase_r == PH_HALT) else $error("error outside halt");
  a_eof_reset: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_end_of_file |=> phase_r == PH_RIFF && err_r == ST_OK)
    else $error("end item did not restart parser");
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_FMT |-> idx_r < 4'd4) else $error("byte index out of range");
endmodule

// ----- rtl/wrhp_queue.sv -----
// Short FIFO of records between the byte walker and the divider/output stage.
// Depends on wrhp_pkg.
module wrhp_queue #(
  parameter int unsigned DEPTH = wrhp_pkg::QueueDepthDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wrhp_pkg::wrhp_rec_t push_rec,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output wrhp_pkg::wrhp_rec_t head
);
  import wrhp_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  wrhp_rec_t         mem_r [DEPTH];
  logic [AW-1:0]     wp_r, rp_r;
  logic [AW:0]       cnt_r;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push && !full)
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop && !empty)
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    full |=> cnt_r <= (AW+1)'(DEPTH)) else $error("queue overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |=> $stable(cnt_r)) else $error("count moved while full");
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    empty && !push |=> empty) else $error("count moved while empty");
endmodule

// ----- rtl/wrhp_back.sv -----
// Back end: drains records, runs a restoring divider for the summary
// duration and drives the output register. Depends on wrhp_pkg.
module wrhp_back #(
  parameter int unsigned FRACTION_BITS = wrhp_pkg::FractionBitsDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  wrhp_pkg::wrhp_rec_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_record_kind,
  output logic [2:0]          out_text_tag,
  output logic [7:0]          out_text_byte,
  output logic [1:0]          out_parse_status,
  output logic [31:0]         out_sample_rate_out,
  output logic [31:0]         out_byte_rate_out,
  output logic [31:0]         out_data_size_out,
  output logic [31:0]         out_track_out,
  output logic [31:0]         out_duration_seconds,
  output logic [15:0]         out_duration_fraction,
  output logic                out_last_flag
);
  import wrhp_pkg::*;

  localparam int unsigned FB = (FRACTION_BITS > 32) ? 32 : FRACTION_BITS;
  localparam int unsigned QW = 32 + FB;
  localparam int unsigned CW = $clog2(QW + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]    st_r;
  logic [CW-1:0] cnt_r;
  logic [QW-1:0] num_r;      // dividend bits shifted out MSB first, quotient in
  logic [32:0]   rem_r;
  logic [31:0]   dvs_r;
  logic          valid_r, valid_nxt;
  wrhp_rec_t     rec_r;
  logic [QW-1:0] quo_r;
  logic [32:0]   trial;
  logic [32:0]   rem_sh;
  logic          div_needed;

  assign div_needed = q_head.status == ST_OK && q_head.sample_rate != 32'd0 &&
                      q_head.byte_rate != 32'd0;
  assign rem_sh = {rem_r[31:0], num_r[QW-1]};
  assign trial  = rem_sh - {1'b0, dvs_r};
  assign q_pop  = (st_r == S_IDLE) && !q_empty && (!valid_r || out_ready);

  always_comb begin
    valid_nxt = valid_r && !out_ready;
    if (q_pop && !(q_head.kind == KIND_SUM && div_needed)) valid_nxt = 1'b1;
    if (st_r == S_OUT && (!valid_r || out_ready)) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; valid_r <= 1'b0; cnt_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      unique case (st_r)
        S_IDLE: if (q_pop) begin
          rec_r <= q_head;
          quo_r <= '0;
          if (q_head.kind == KIND_SUM && div_needed) begin
            st_r  <= S_DIV;
            cnt_r <= CW'(QW);
            num_r <= QW'(q_head.data_size) << FB;
            rem_r <= '0;
            dvs_r <= q_head.byte_rate;
          end
        end
        S_DIV: begin
          // one quotient bit per cycle
          if (!trial[32]) rem_r <= trial;
          else rem_r <= rem_sh;
          num_r <= {num_r[QW-2:0], !trial[32]};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CW'(1)) st_r <= S_OUT;
        end
        S_OUT: if (!valid_r || out_ready) begin
          quo_r <= num_r;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  logic [QW+31:0] quo_ext;
  assign quo_ext = {32'd0, quo_r};

  assign out_valid            = valid_r;
  assign out_record_kind      = rec_r.kind;
  assign out_text_tag         = rec_r.tag;
  assign out_text_byte        = rec_r.text;
  assign out_parse_status     = rec_r.status;
  assign out_sample_rate_out  = rec_r.sample_rate;
  assign out_byte_rate_out    = rec_r.byte_rate;
  assign out_data_size_out    = rec_r.data_size;
  assign out_track_out        = rec_r.track;
  assign out_duration_seconds = quo_ext[FB +: 32];
  assign out_duration_fraction = (FB == 0) ? 16'd0 :
                                 16'(quo_ext[31:0] & ((64'd1 << FB) - 64'd1));
  assign out_last_flag        = (rec_r.kind == KIND_SUM);

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DIV |-> rem_r < {1'b0, dvs_r}) else $error("remainder not reduced");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IDLE |-> !q_pop) else $error("pop during divide");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ready |=> valid_r && $stable(rec_r)) else $error("record dropped");
endmodule
